/* src/kf3_pkg.sv */
// Shared constants, register indexes, multiplier step codes and control structs.
package kf3_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int VAR_W     = 31;
   localparam int PROD_W    = 2 * POS_W;
   localparam int CSR_IDX_W = 2;

   // Divider runs one quotient bit per cycle
   localparam int DIV_STEPS = POS_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_MEAS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INIT = 2'd2;

   // Register reset values: 8.0 and 4.0 in the fixed-point format
   localparam logic [VAR_W-1:0] MEAS_RESET = VAR_W'(8 << FRAC_BITS);
   localparam logic [VAR_W-1:0] PROC_RESET = VAR_W'(4 << FRAC_BITS);
   localparam logic [VAR_W-1:0] INIT_RESET = '0;
   localparam logic [VAR_W-1:0] VAR_MAX    = '1;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Multiplier step codes, issued in this order
   localparam logic [2:0] MUL_X_EST = 3'd0;
   localparam logic [2:0] MUL_X_OBS = 3'd1;
   localparam logic [2:0] MUL_Y_EST = 3'd2;
   localparam logic [2:0] MUL_Y_OBS = 3'd3;
   localparam logic [2:0] MUL_Z_EST = 3'd4;
   localparam logic [2:0] MUL_Z_OBS = 3'd5;
   localparam logic [2:0] MUL_VAR   = 3'd6;
   localparam logic [2:0] MUL_LAST  = MUL_VAR;

   // Controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       mul_go;
      logic [2:0] mul_idx;
      logic       div_start;
      logic       blend;
      logic       predict;
      logic       load_init;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_busy;
   } stat_type;

endpackage

/* src/kf3_div.sv */
// Iterative restoring divider lane: signed 64-bit numerator by unsigned 32-bit denominator.
module kf3_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [kf3_pkg::PROD_W-1:0]  num_i,
   input  logic        [kf3_pkg::POS_W-1:0]   den_i,
   output logic                               busy,
   output logic signed [kf3_pkg::POS_W-1:0]   quot
);
   import kf3_pkg::*;

   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [POS_W-1:0]     quo_ff, quo_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   logic [PROD_W-1:0] mag;
   logic [POS_W:0]    shifted;
   logic [POS_W:0]    trial;
   logic              fits;

   // Magnitude of the numerator; truncation toward zero works on magnitudes.
   // The quotient is known to fit in 32 bits, so the high half starts below the divisor.
   assign mag     = num_i[PROD_W-1] ? PROD_W'(-num_i) : PROD_W'(num_i);
   assign shifted = {rem_ff, quo_ff[POS_W-1]};
   assign trial   = shifted - {1'b0, den_i};
   assign fits    = shifted >= {1'b0, den_i};

   // One quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = mag[PROD_W-1:POS_W];
         quo_in  = mag[POS_W-1:0];
         neg_in  = num_i[PROD_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[POS_W-1:0] : shifted[POS_W-1:0];
         quo_in = {quo_ff[POS_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // Apply the sign and saturate to the 32-bit range
   always_comb begin
      if (neg_ff) begin
         quot = (quo_ff > {1'b1, {(POS_W-1){1'b0}}}) ? POS_MIN : $signed(POS_W'(0 - quo_ff));
      end else begin
         quot = quo_ff[POS_W-1] ? POS_MAX : $signed(quo_ff);
      end
   end

   assign busy = busy_ff;

endmodule

/* src/kf3_dp.sv */
// Datapath: registers, shared multiplier, four divider lanes, blend and prediction.
module kf3_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  kf3_pkg::cmd_type                    cmd,
   output kf3_pkg::stat_type                   stat,
   input  logic                                csr_write,
   input  logic        [kf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [kf3_pkg::VAR_W-1:0]    csr_wdata,
   input  logic signed [kf3_pkg::POS_W-1:0]    req_obs_x,
   input  logic signed [kf3_pkg::POS_W-1:0]    req_obs_y,
   input  logic signed [kf3_pkg::POS_W-1:0]    req_obs_z,
   input  logic signed [kf3_pkg::POS_W-1:0]    req_delta_x,
   input  logic signed [kf3_pkg::POS_W-1:0]    req_delta_y,
   input  logic signed [kf3_pkg::POS_W-1:0]    req_delta_z,
   output logic signed [kf3_pkg::POS_W-1:0]    rsp_est_x,
   output logic signed [kf3_pkg::POS_W-1:0]    rsp_est_y,
   output logic signed [kf3_pkg::POS_W-1:0]    rsp_est_z,
   output logic        [kf3_pkg::VAR_W-1:0]    rsp_est_variance
);
   import kf3_pkg::*;

   // Configuration registers
   logic [VAR_W-1:0] meas_ff, meas_in;
   logic [VAR_W-1:0] proc_ff, proc_in;
   logic [VAR_W-1:0] init_ff, init_in;

   // Filter state
   logic signed [POS_W-1:0] est_ff [3];
   logic signed [POS_W-1:0] est_in [3];
   logic        [VAR_W-1:0] var_ff, var_in;

   // Captured input word
   logic signed [POS_W-1:0] obs_ff   [3];
   logic signed [POS_W-1:0] obs_in   [3];
   logic signed [POS_W-1:0] delta_ff [3];
   logic signed [POS_W-1:0] delta_in [3];

   // Multiplier pipeline and blend numerators (x, y, z, variance)
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     mul_vld_ff, mul_vld_in;
   logic [2:0]               mul_idx_ff, mul_idx_in;
   logic signed [PROD_W-1:0] num_ff [4];
   logic signed [PROD_W-1:0] num_in [4];

   // Result word
   logic signed [POS_W-1:0] rsp_est_ff [3];
   logic signed [POS_W-1:0] rsp_est_in [3];
   logic        [VAR_W-1:0] rsp_var_ff, rsp_var_in;

   logic signed [POS_W-1:0] mul_a, mul_b;
   logic        [POS_W-1:0] den;
   logic signed [POS_W-1:0] quot [4];
   logic        [3:0]       lane_busy;
   logic signed [POS_W:0]   pos_sum [3];
   logic        [VAR_W:0]   var_sum;

   // Blend denominator P + Rm
   assign den = {1'b0, var_ff} + {1'b0, meas_ff};

   // Operand selection for the shared multiplier
   always_comb begin
      unique case (cmd.mul_idx)
         MUL_X_EST: begin mul_a = $signed({1'b0, meas_ff}); mul_b = est_ff[0]; end
         MUL_X_OBS: begin mul_a = $signed({1'b0, var_ff});  mul_b = obs_ff[0]; end
         MUL_Y_EST: begin mul_a = $signed({1'b0, meas_ff}); mul_b = est_ff[1]; end
         MUL_Y_OBS: begin mul_a = $signed({1'b0, var_ff});  mul_b = obs_ff[1]; end
         MUL_Z_EST: begin mul_a = $signed({1'b0, meas_ff}); mul_b = est_ff[2]; end
         MUL_Z_OBS: begin mul_a = $signed({1'b0, var_ff});  mul_b = obs_ff[2]; end
         default:   begin mul_a = $signed({1'b0, var_ff});  mul_b = $signed({1'b0, meas_ff}); end
      endcase
   end

   assign prod_in    = mul_a * mul_b;
   assign mul_vld_in = cmd.mul_go;
   assign mul_idx_in = cmd.mul_idx;

   // Saturating prediction sums
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pos_sum[a] = {est_ff[a][POS_W-1], est_ff[a]} + {delta_ff[a][POS_W-1], delta_ff[a]};
      end
      var_sum = {1'b0, var_ff} + {1'b0, proc_ff};
   end

   // Next-state logic for all datapath registers
   always_comb begin
      meas_in    = meas_ff;
      proc_in    = proc_ff;
      init_in    = init_ff;
      var_in     = var_ff;
      rsp_var_in = rsp_var_ff;
      for (int a = 0; a < 3; a++) begin
         est_in[a]     = est_ff[a];
         obs_in[a]     = obs_ff[a];
         delta_in[a]   = delta_ff[a];
         rsp_est_in[a] = rsp_est_ff[a];
      end
      for (int k = 0; k < 4; k++) begin
         num_in[k] = num_ff[k];
      end

      // Register writes; unknown indexes are dropped
      if (csr_write) begin
         unique case (csr_index)
            REG_MEAS: meas_in = csr_wdata;
            REG_PROC: proc_in = csr_wdata;
            REG_INIT: init_in = csr_wdata;
            default:  ;
         endcase
      end

      if (cmd.capture) begin
         obs_in[0]   = req_obs_x;
         obs_in[1]   = req_obs_y;
         obs_in[2]   = req_obs_z;
         delta_in[0] = req_delta_x;
         delta_in[1] = req_delta_y;
         delta_in[2] = req_delta_z;
      end

      // Build numerators from the registered product, in the cycle after each multiply
      if (mul_vld_ff) begin
         unique case (mul_idx_ff)
            MUL_X_EST: num_in[0] = prod_ff;
            MUL_X_OBS: num_in[0] = num_ff[0] + prod_ff;
            MUL_Y_EST: num_in[1] = prod_ff;
            MUL_Y_OBS: num_in[1] = num_ff[1] + prod_ff;
            MUL_Z_EST: num_in[2] = prod_ff;
            MUL_Z_OBS: num_in[2] = num_ff[2] + prod_ff;
            default:   num_in[3] = prod_ff;
         endcase
      end

      // Measurement update; a zero denominator keeps the estimates and clears P
      if (cmd.blend) begin
         if (den != '0) begin
            for (int a = 0; a < 3; a++) begin
               est_in[a] = quot[a];
            end
            var_in = quot[3][VAR_W-1:0];
         end else begin
            var_in = '0;
         end
      end

      if (cmd.predict) begin
         for (int a = 0; a < 3; a++) begin
            if (pos_sum[a][POS_W] != pos_sum[a][POS_W-1]) begin
               est_in[a] = pos_sum[a][POS_W] ? POS_MIN : POS_MAX;
            end else begin
               est_in[a] = pos_sum[a][POS_W-1:0];
            end
         end
         var_in = var_sum[VAR_W] ? VAR_MAX : var_sum[VAR_W-1:0];
      end

      // Initialization from the observation
      if (cmd.load_init) begin
         for (int a = 0; a < 3; a++) begin
            est_in[a] = obs_ff[a];
         end
         var_in = init_ff;
      end

      if (cmd.rsp_load) begin
         for (int a = 0; a < 3; a++) begin
            rsp_est_in[a] = est_ff[a];
         end
         rsp_var_in = var_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_ff    <= MEAS_RESET;
         proc_ff    <= PROC_RESET;
         init_ff    <= INIT_RESET;
         var_ff     <= '0;
         mul_vld_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            est_ff[a] <= '0;
         end
      end else begin
         meas_ff    <= meas_in;
         proc_ff    <= proc_in;
         init_ff    <= init_in;
         var_ff     <= var_in;
         mul_vld_ff <= mul_vld_in;
         for (int a = 0; a < 3; a++) begin
            est_ff[a] <= est_in[a];
         end
      end
      prod_ff    <= prod_in;
      mul_idx_ff <= mul_idx_in;
      rsp_var_ff <= rsp_var_in;
      for (int a = 0; a < 3; a++) begin
         obs_ff[a]     <= obs_in[a];
         delta_ff[a]   <= delta_in[a];
         rsp_est_ff[a] <= rsp_est_in[a];
      end
      for (int k = 0; k < 4; k++) begin
         num_ff[k] <= num_in[k];
      end
   end

   // Divider lanes: one per axis and one for the variance
   for (genvar g = 0; g < 4; g++) begin : g_lane
      kf3_div u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .num_i (num_ff[g]),
         .den_i (den),
         .busy  (lane_busy[g]),
         .quot  (quot[g])
      );
   end

   // All lanes start together and finish together
   assign stat.div_busy = |lane_busy;

   assign rsp_est_x        = rsp_est_ff[0];
   assign rsp_est_y        = rsp_est_ff[1];
   assign rsp_est_z        = rsp_est_ff[2];
   assign rsp_est_variance = rsp_var_ff;

endmodule

/* src/kf3_ctrl.sv */
// Controller: sequences multiply, divide, blend, predict or initialization load, and result hand-off for one word.
module kf3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_mode,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  kf3_pkg::stat_type  stat,
   output kf3_pkg::cmd_type   cmd
);
   import kf3_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_DIVS  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_BLEND = 3'd5;
   localparam logic [2:0] S_PRED  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;
   localparam logic [2:0] S_LOAD  = S_ACC;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // State sequencing and command decode
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.mul_idx = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               mode_in     = req_mode;
               cnt_in      = MUL_X_EST;
               state_in    = req_mode ? S_MUL : S_LOAD;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            // Mode 0 loads here; mode 1 lets the last product settle.
            if (!mode_ff) begin
               cmd.load_init = 1'b1;
               state_in      = S_OUT;
            end else begin
               state_in = S_DIVS;
            end
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = S_PRED;
         end
         S_PRED: begin
            cmd.predict = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The result word holds until taken
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/kalman_filter_1d_three_axis.sv */
// Top level of the three-axis scalar Kalman position tracker.
//
//   channel   direction  handshake              word
//   req       in         req_valid/req_ready    mode, obs_x/y/z, delta_x/y/z
//   rsp       out        rsp_valid/rsp_ready    est_x/y/z, est_variance
//   csr       in         csr_valid/csr_ready    csr_index, csr_wdata (31 bits)
//
// An update word goes from acceptance to a loaded result through the shared 32x32
// multiplier, settle and start steps, the four radix-2 divider lanes that run side
// by side, and divider-done, blend, predict and hand-off steps. An initialization word
// loads the observation and goes to hand-off. One word is in flight at a time; the next
// word is accepted while a finished result still waits in the output register.
// Reset is synchronous and restores the register defaults and a zero estimate.
// Configuration writes are always taken.
module kalman_filter_1d_three_axis (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic signed [kf3_pkg::POS_W-1:0]     req_obs_x,
   input  logic signed [kf3_pkg::POS_W-1:0]     req_obs_y,
   input  logic signed [kf3_pkg::POS_W-1:0]     req_obs_z,
   input  logic signed [kf3_pkg::POS_W-1:0]     req_delta_x,
   input  logic signed [kf3_pkg::POS_W-1:0]     req_delta_y,
   input  logic signed [kf3_pkg::POS_W-1:0]     req_delta_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [kf3_pkg::POS_W-1:0]     rsp_est_x,
   output logic signed [kf3_pkg::POS_W-1:0]     rsp_est_y,
   output logic signed [kf3_pkg::POS_W-1:0]     rsp_est_z,
   output logic        [kf3_pkg::VAR_W-1:0]     rsp_est_variance,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [kf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [kf3_pkg::VAR_W-1:0]     csr_wdata
);
   import kf3_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   kf3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   kf3_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_obs_x        (req_obs_x),
      .req_obs_y        (req_obs_y),
      .req_obs_z        (req_obs_z),
      .req_delta_x      (req_delta_x),
      .req_delta_y      (req_delta_y),
      .req_delta_z      (req_delta_z),
      .rsp_est_x        (rsp_est_x),
      .rsp_est_y        (rsp_est_y),
      .rsp_est_z        (rsp_est_z),
      .rsp_est_variance (rsp_est_variance)
   );

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending word");

   // Starting the dividers makes them busy on the next cycle.
   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> stat.div_busy)
      else $error("divider lanes did not start");

   // The blend only reads finished quotients.
   a_blend_done: assert property (@(posedge clock) disable iff (reset)
      cmd.blend |-> !stat.div_busy)
      else $error("blend while dividers still running");

   // One word at a time: after acceptance the input is closed on the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while one is in flight");

endmodule
